// File: src/scmva_pkg.sv
// Shared types, codes and helpers for the sparse complex mat-vec accumulator.
package scmva_pkg;

  localparam int unsigned INDEX_BITS_DEF = 16;

  localparam int unsigned IDX_FIELD_W = 16;
  localparam int unsigned VEC_W       = 24;
  localparam int unsigned ENT_W       = 16;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned PROD_W      = VEC_W + ENT_W;  // one real product
  localparam int unsigned PART_W      = PROD_W + 1;     // sum of two products
  localparam int unsigned SUM_W       = ACC_W + 1;      // accumulator add before clamp
  localparam int unsigned CFG_W       = 17;

  localparam int unsigned S_TDATA_W = 144;
  localparam int unsigned M_TDATA_W = 112;

  // item kinds on s_axis_tuser
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic REG_ADJOINT   = 1'b0;
  localparam logic REG_ROW_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] ROW_LIMIT_RST = 17'h10000;

  typedef struct packed {
    logic                    adj;
    logic signed [ENT_W-1:0] er;
    logic signed [ENT_W-1:0] ei;
    logic signed [VEC_W-1:0] xr;
    logic signed [VEC_W-1:0] xi;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic                    flag;
  } mac_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic                    flag;
  } mac_rsp_t;

  // clamp a 49-bit sum to 48 bits; top bit of the result is the overflow flag
  function automatic logic [ACC_W:0] sat_acc(input logic [SUM_W-1:0] s);
    logic [ACC_W:0] r;
    if (s[SUM_W-1] != s[SUM_W-2]) begin
      r = s[SUM_W-1] ? {1'b1, 1'b1, {(ACC_W-1){1'b0}}} : {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = {1'b0, s[ACC_W-1:0]};
    end
    return r;
  endfunction

endpackage

// File: src/scmva_cmac.sv
// Complex multiply-accumulate over six steps of one multiplier and one adder.
module scmva_cmac
  import scmva_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_1    = 3'd1;
  localparam logic [2:0] STEP_2    = 3'd2;
  localparam logic [2:0] STEP_3    = 3'd3;
  localparam logic [2:0] STEP_4    = 3'd4;
  localparam logic [2:0] STEP_5    = 3'd5;

  logic [2:0] step_q, step_d;
  logic       done_q, done_d;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PART_W-1:0] part_q, part_d;
  logic signed [ACC_W-1:0]  re_q, re_d;
  logic signed [ACC_W-1:0]  im_q, im_d;
  logic                     ovf_q, ovf_d;

  logic signed [ENT_W-1:0]  mul_a;
  logic signed [VEC_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SUM_W-1:0]  add_a, add_b, add_s;
  logic                     add_sub;
  logic [ACC_W:0]           sat_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = req_i.er;
    mul_b = req_i.xr;
    case (step_q)
      STEP_1: begin
        mul_a = req_i.ei;
        mul_b = req_i.xi;
      end
      STEP_2: begin
        mul_a = req_i.er;
        mul_b = req_i.xi;
      end
      STEP_3: begin
        mul_a = req_i.ei;
        mul_b = req_i.xr;
      end
      default: begin
        mul_a = req_i.er;
        mul_b = req_i.xr;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // operand select for the shared adder
  always_comb begin
    add_a   = {{(SUM_W-PART_W){part_q[PART_W-1]}}, part_q};
    add_b   = {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    add_sub = 1'b0;
    case (step_q)
      STEP_2: add_sub = !req_i.adj;  // real part: er*xr -/+ ei*xi
      STEP_3: begin
        add_a = {req_i.acc_re[ACC_W-1], req_i.acc_re};
        add_b = {{(SUM_W-PART_W){part_q[PART_W-1]}}, part_q};
      end
      STEP_4: add_sub = req_i.adj;   // imag part: er*xi +/- ei*xr
      STEP_5: begin
        add_a = {req_i.acc_im[ACC_W-1], req_i.acc_im};
        add_b = {{(SUM_W-PART_W){part_q[PART_W-1]}}, part_q};
      end
      default: add_sub = 1'b0;
    endcase
  end

  assign add_s = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign sat_r = sat_acc(add_s);

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    prod_d = prod_q;
    part_d = part_q;
    re_d   = re_q;
    im_d   = im_q;
    ovf_d  = ovf_q;
    case (step_q)
      STEP_IDLE: begin
        if (start_i) begin
          prod_d = mul_p;
          step_d = STEP_1;
        end
      end
      STEP_1: begin
        part_d = {prod_q[PROD_W-1], prod_q};
        prod_d = mul_p;
        step_d = STEP_2;
      end
      STEP_2: begin
        part_d = add_s[PART_W-1:0];
        prod_d = mul_p;
        step_d = STEP_3;
      end
      STEP_3: begin
        re_d   = sat_r[ACC_W-1:0];
        ovf_d  = req_i.flag | sat_r[ACC_W];
        part_d = {prod_q[PROD_W-1], prod_q};
        prod_d = mul_p;
        step_d = STEP_4;
      end
      STEP_4: begin
        part_d = add_s[PART_W-1:0];
        step_d = STEP_5;
      end
      STEP_5: begin
        im_d   = sat_r[ACC_W-1:0];
        ovf_d  = ovf_q | sat_r[ACC_W];
        done_d = 1'b1;
        step_d = STEP_IDLE;
      end
      default: step_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    part_q <= part_d;
    re_q   <= re_d;
    im_q   <= im_d;
    ovf_q  <= ovf_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.acc_re = re_q;
  assign rsp_o.acc_im = im_q;
  assign rsp_o.flag   = ovf_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> step_q == STEP_IDLE)
    else $error("cmac started while busy");

  a_done_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(step_q) == STEP_5)
    else $error("cmac done without final step");

  a_flag_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && req_i.flag |-> ovf_q)
    else $error("saturation flag lost");

endmodule

// File: src/sparse_complex_matvec_accumulator.sv
// Sparse complex mat-vec accumulator top level: memories, sequencer and output register.
//
// Complex sparse matrix-vector multiply over coordinate-format nonzeros. A load beat
// (tuser kind 0) writes one source element. An entry beat (kind 1) does
// acc[row] += val*x[col], or acc[col] += conj(val)*x[row] in adjoint mode: after the
// memory read, one 16x24 multiplier and one 49-bit adder are stepped through six steps,
// then the result is written back. Entries with row >= row_limit are dropped. A read
// beat (kind 2) returns and clears one accumulator element with its sticky saturation
// flag, and waits while the output register is held. After reset the accumulator
// memory is cleared one entry a cycle, all 2^INDEX_BITS entries, during which no beat
// is taken; configuration writes are taken at any time.
module sparse_complex_matvec_accumulator
  import scmva_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // source_index, vector_re, vector_im, entry_row, entry_col, entry_re, entry_im,
  // result_index
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,   // kind
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // out_index, sum_re, sum_im
  output logic                 m_axis_tuser    // saturated
);

  localparam int unsigned DEPTH  = 2 ** INDEX_BITS;
  localparam int unsigned ENTRY_W = 2 * ACC_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ENTRY = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [2:0] state_q, state_d;

  logic             adj_q;
  logic [CFG_W-1:0] row_limit_q;

  logic [INDEX_BITS-1:0] clr_q, clr_d;
  logic [INDEX_BITS-1:0] addr_q;
  logic signed [ENT_W-1:0] er_q, ei_q;

  // input fields
  logic [IDX_FIELD_W-1:0] f_src_idx, f_row, f_col, f_res_idx;
  logic [VEC_W-1:0]       f_vre, f_vim;
  logic [ENT_W-1:0]       f_ere, f_eim;

  assign f_src_idx = s_axis_tdata[15:0];
  assign f_vre     = s_axis_tdata[39:16];
  assign f_vim     = s_axis_tdata[63:40];
  assign f_row     = s_axis_tdata[79:64];
  assign f_col     = s_axis_tdata[95:80];
  assign f_ere     = s_axis_tdata[111:96];
  assign f_eim     = s_axis_tdata[127:112];
  assign f_res_idx = s_axis_tdata[143:128];

  logic accept, row_ok;
  logic [INDEX_BITS-1:0] src_raddr, acc_raddr;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign row_ok = {1'b0, f_row} < row_limit_q;

  assign src_raddr = adj_q ? INDEX_BITS'(f_row) : INDEX_BITS'(f_col);
  always_comb begin
    if (s_axis_tuser == KIND_READ) begin
      acc_raddr = INDEX_BITS'(f_res_idx);
    end else begin
      acc_raddr = adj_q ? INDEX_BITS'(f_col) : INDEX_BITS'(f_row);
    end
  end

  // memories
  logic [2*VEC_W-1:0]   src_mem [DEPTH];
  logic [ENTRY_W-1:0]   acc_mem [DEPTH];
  logic [2*VEC_W-1:0]   src_rd_q;
  logic [ENTRY_W-1:0]   acc_rd_q;

  logic                  src_we, rd_en;
  logic                  acc_we;
  logic [INDEX_BITS-1:0] acc_waddr;
  logic [ENTRY_W-1:0]    acc_wdata;

  assign src_we = accept && (s_axis_tuser == KIND_LOAD);
  assign rd_en  = accept && ((s_axis_tuser == KIND_ENTRY && row_ok) ||
                             s_axis_tuser == KIND_READ);

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[INDEX_BITS'(f_src_idx)] <= {f_vim, f_vre};
    end
    if (rd_en) begin
      src_rd_q <= src_mem[src_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (rd_en) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
  end

  // shared multiply-accumulate unit
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;
  logic     mac_start;

  assign mac_start      = (state_q == ST_ENTRY);
  assign mac_req.adj    = adj_q;
  assign mac_req.er     = er_q;
  assign mac_req.ei     = ei_q;
  assign mac_req.xr     = src_rd_q[VEC_W-1:0];
  assign mac_req.xi     = src_rd_q[2*VEC_W-1:VEC_W];
  assign mac_req.acc_re = acc_rd_q[ACC_W-1:0];
  assign mac_req.acc_im = acc_rd_q[2*ACC_W-1:ACC_W];
  assign mac_req.flag   = acc_rd_q[ENTRY_W-1];

  scmva_cmac u_cmac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .req_i   (mac_req),
    .rsp_o   (mac_rsp)
  );

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 out_sat_q;

  assign out_load = (state_q == ST_READ) && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {acc_rd_q[2*ACC_W-1:ACC_W], acc_rd_q[ACC_W-1:0],
                     IDX_FIELD_W'(addr_q)};
      out_sat_q  <= acc_rd_q[ENTRY_W-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;
  assign s_axis_tready = (state_q == ST_IDLE);

  // accumulator write port: clear pass, entry write back, read-and-clear
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = addr_q;
    acc_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_q;
      end
      ST_MAC: begin
        acc_we    = mac_rsp.done;
        acc_wdata = {mac_rsp.flag, mac_rsp.acc_im, mac_rsp.acc_re};
      end
      ST_READ: acc_we = out_load;
      default: acc_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {INDEX_BITS{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == KIND_ENTRY && row_ok) begin
            state_d = ST_ENTRY;
          end else if (s_axis_tuser == KIND_READ) begin
            state_d = ST_READ;
          end
        end
      end
      ST_ENTRY: state_d = ST_MAC;
      ST_MAC: begin
        if (mac_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      adj_q       <= 1'b0;
      row_limit_q <= ROW_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ADJOINT:   adj_q       <= cfg_wdata_i[0];
          REG_ROW_LIMIT: row_limit_q <= cfg_wdata_i;
          default:       adj_q       <= adj_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      addr_q <= acc_raddr;
      er_q   <= f_ere;
      ei_q   <= f_eim;
    end
  end

  a_done_in_mac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.done |-> state_q == ST_MAC)
    else $error("mac result outside write-back state");

  a_entry_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser == KIND_ENTRY && row_ok |=> state_q == ST_ENTRY)
    else $error("in-range entry did not start the mac");

  a_read_goes_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ && state_d == ST_IDLE |=> out_valid_q)
    else $error("read item left no result");

endmodule
